@@ rtl/sfd_pkg.sv @@
// Shared constants, register codes and stage control types for the stereo delay.
package sfd_pkg;

  localparam int COEF_BITS  = 16;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 3;

  localparam logic [16:0] UNITY     = 17'h10000;
  localparam logic [15:0] FB_MAX    = 16'd62259;
  localparam logic [16:0] DELAY_RST = 17'd24000;
  localparam logic [16:0] WET_RST   = 17'd32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY     = 3'd0,
    REG_FEEDBACK  = 3'd1,
    REG_WET       = 3'd2,
    REG_DAMPING   = 3'd3,
    REG_PING_PONG = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic mul_en;
    logic sum_en;
    logic fbm_en;
  } sfd_ctl_t;

  typedef struct packed {
    logic [15:0] damp_c;
    logic [16:0] damp_cm;
    logic [16:0] wet;
    logic [16:0] dry;
    logic [15:0] fb;
  } sfd_coef_t;

endpackage

@@ rtl/sfd_if.sv @@
// Valid/ready stream interfaces for the input and result sample pairs.
interface sfd_in_if #(parameter int SAMPLE_BITS = 24) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;

  modport source(output valid, output left_in, output right_in, input ready);
  modport sink(input valid, input left_in, input right_in, output ready);
endinterface

interface sfd_out_if #(parameter int SAMPLE_BITS = 24) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;

  modport source(output valid, output left_out, output right_out, input ready);
  modport sink(input valid, input left_out, input right_out, output ready);
endinterface

@@ rtl/sfd_store.sv @@
// Left and right circular delay memories, one write and one registered read port.
module sfd_store #(
  parameter int DEPTH = 131072,
  parameter int SB    = 24,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic signed [SB-1:0] wdata_l,
  input  logic signed [SB-1:0] wdata_r,
  input  logic [AW-1:0]        raddr,
  output logic signed [SB-1:0] rdata_l,
  output logic signed [SB-1:0] rdata_r
);

  logic [SB-1:0] mem_l [DEPTH];
  logic [SB-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_l[waddr] <= wdata_l;
      mem_r[waddr] <= wdata_r;
    end
    rdata_l <= mem_l[raddr];
    rdata_r <= mem_r[raddr];
  end

endmodule

@@ rtl/sfd_lane.sv @@
// One channel lane: damping lowpass, feedback scaling and dry/wet mix.
module sfd_lane #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sfd_pkg::sfd_ctl_t             ctl,
  input  sfd_pkg::sfd_coef_t            coef,
  input  logic signed [SAMPLE_BITS-1:0] dry_smp,
  input  logic signed [SAMPLE_BITS-1:0] del_smp,
  output logic signed [SAMPLE_BITS:0]   fb_term,
  output logic signed [SAMPLE_BITS-1:0] mix_out
);
  import sfd_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int DS = 32 - SB;
  localparam int FS = COEF_BITS + DS;
  localparam int MW = SB + 19;
  localparam int RW = SB + 3;
  localparam logic signed [50:0]   DHALF = 51'sd1 <<< (COEF_BITS - 1);
  localparam logic signed [MW-1:0] MHALF = MW'(51'sd1 <<< (COEF_BITS - 1));
  localparam logic signed [48:0]   FHALF = 49'sd1 <<< (FS - 1);

  logic signed [31:0]   damp_r;
  logic signed [31:0]   damp_nxt;
  logic signed [48:0]   pst_r;
  logic signed [49:0]   pdl_r;
  logic signed [SB+17:0] pdry_r;
  logic signed [SB+17:0] pwet_r;
  logic signed [48:0]   pfb_r;
  logic signed [SB-1:0] mix_r;
  logic signed [SB-1:0] mix_nxt;
  logic signed [31:0]   x;
  logic signed [50:0]   dsum;
  logic signed [MW-1:0] msum;
  logic signed [RW-1:0] mrnd;
  logic signed [48:0]   fsum;

  always_comb begin
    x    = 32'(del_smp) <<< DS;
    dsum = 51'(pst_r) + 51'(pdl_r) + DHALF;
    damp_nxt = 32'(dsum >>> COEF_BITS);
    msum = MW'(pdry_r) + MW'(pwet_r) + MHALF;
    mrnd = RW'(msum >>> COEF_BITS);
    if ((&mrnd[RW-1:SB-1]) || !(|mrnd[RW-1:SB-1])) begin
      mix_nxt = mrnd[SB-1:0];
    end else if (mrnd[RW-1]) begin
      mix_nxt = {1'b1, {(SB-1){1'b0}}};
    end else begin
      mix_nxt = {1'b0, {(SB-1){1'b1}}};
    end
    fsum    = pfb_r + FHALF;
    fb_term = (SB+1)'(fsum >>> FS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      damp_r <= '0;
    end else if (ctl.sum_en) begin
      damp_r <= damp_nxt;
    end
    if (ctl.mul_en) begin
      pst_r  <= damp_r * $signed({1'b0, coef.damp_c});
      pdl_r  <= x * $signed({1'b0, coef.damp_cm});
      pdry_r <= dry_smp * $signed({1'b0, coef.dry});
      pwet_r <= del_smp * $signed({1'b0, coef.wet});
    end
    if (ctl.sum_en) begin
      mix_r <= mix_nxt;
    end
    if (ctl.fbm_en) begin
      pfb_r <= damp_r * $signed({1'b0, coef.fb});
    end
  end

  assign mix_out = mix_r;

endmodule

@@ rtl/sfd_merge.sv @@
// Merge of the two lanes: normal or ping-pong feedback routing and write saturation.
module sfd_merge #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          ping_pong,
  input  logic signed [SAMPLE_BITS-1:0] left_smp,
  input  logic signed [SAMPLE_BITS-1:0] right_smp,
  input  logic signed [SAMPLE_BITS:0]   fb_left,
  input  logic signed [SAMPLE_BITS:0]   fb_right,
  output logic signed [SAMPLE_BITS-1:0] wr_left,
  output logic signed [SAMPLE_BITS-1:0] wr_right
);

  localparam int SB = SAMPLE_BITS;

  logic signed [SB:0]   pair_sum;
  logic signed [SB+1:0] mono;
  logic signed [SB+1:0] sum_l;
  logic signed [SB+1:0] sum_r;

  function automatic logic signed [SB-1:0] sat_smp(input logic signed [SB+1:0] v);
    logic signed [SB-1:0] res;
    if ((&v[SB+1:SB-1]) || !(|v[SB+1:SB-1])) begin
      res = v[SB-1:0];
    end else if (v[SB+1]) begin
      res = {1'b1, {(SB-1){1'b0}}};
    end else begin
      res = {1'b0, {(SB-1){1'b1}}};
    end
    return res;
  endfunction

  always_comb begin
    pair_sum = (SB+1)'(left_smp) + (SB+1)'(right_smp);
    mono     = (SB+2)'(pair_sum >>> 1);
    if (ping_pong) begin
      sum_l = mono + (SB+2)'(fb_right);
      sum_r = (SB+2)'(fb_left);
    end else begin
      sum_l = (SB+2)'(left_smp) + (SB+2)'(fb_left);
      sum_r = (SB+2)'(right_smp) + (SB+2)'(fb_right);
    end
    wr_left  = sat_smp(sum_l);
    wr_right = sat_smp(sum_r);
  end

endmodule

@@ rtl/stereo_feedback_delay.sv @@
// Top level: stereo feedback delay with damping, ping-pong routing and dry/wet mix.
//
//   channel   direction  carries                        handshake
//   in_if     sink       left_in, right_in per item     valid/ready
//   out_if    source     left_out, right_out per item   valid/ready
//   cfg_*     input      cfg_index, cfg_wdata           cfg_wr_en, no wait
//
// An item passes through accept with memory read, lane multiply, lowpass and mix
// sum, feedback multiply, then merge and store write; the two dependent multiply
// and round steps of each lane set that order. A new item waits for the write.
// Synchronous reset clears control and damping state and sets register defaults; a
// wrap flag makes unwritten store entries read as zero, so no clearing pass runs.
// A result waits in the output register; the write stage holds until it is free.
module stereo_feedback_delay #(
  parameter int DELAY_DEPTH = 131072,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                             clk,
  input  logic                             rst_n,
  sfd_in_if.sink                           in_if,
  sfd_out_if.source                        out_if,
  input  logic                             cfg_wr_en,
  input  logic [sfd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sfd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import sfd_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int AW = $clog2(DELAY_DEPTH);
  localparam int DW = ((AW > CFG_DATA_W) ? AW : CFG_DATA_W) + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_FBM,
    ST_WR
  } state_t;

  state_t        state_r;
  logic [16:0]   delay_r;
  logic [15:0]   feedback_r;
  logic [16:0]   wet_r;
  logic [15:0]   damping_r;
  logic          ping_pong_r;

  logic [AW-1:0] wi_r;
  logic [AW-1:0] wi_nxt;
  logic          wi_wrap;
  logic          wrapped_r;
  logic          fill_ok;
  logic          fill_ok_r;
  logic signed [SB-1:0] left_r;
  logic signed [SB-1:0] right_r;
  logic          out_valid_r;
  logic signed [SB-1:0] left_out_r;
  logic signed [SB-1:0] right_out_r;

  logic          in_fire;
  logic          out_fire;
  logic          out_free;
  logic          mem_we;
  logic [DW-1:0] d_ext;
  logic [DW-1:0] d_eff;
  logic [DW-1:0] wi_ext;
  logic [DW-1:0] rd_ext;
  logic [AW-1:0] rd_addr;

  logic signed [SB-1:0] rdata_l;
  logic signed [SB-1:0] rdata_r;
  logic signed [SB-1:0] del_l;
  logic signed [SB-1:0] del_r;
  logic signed [SB:0]   fb_l;
  logic signed [SB:0]   fb_r;
  logic signed [SB-1:0] mix_l;
  logic signed [SB-1:0] mix_r;
  logic signed [SB-1:0] wr_l;
  logic signed [SB-1:0] wr_r;

  sfd_ctl_t  ctl;
  sfd_coef_t coef;

  assign in_if.ready      = rst_n && (state_r == ST_IDLE);
  assign in_fire          = in_if.valid & in_if.ready;
  assign out_fire         = out_valid_r & out_if.ready;
  assign out_free         = !out_valid_r || out_if.ready;
  assign mem_we           = (state_r == ST_WR) && out_free;
  assign out_if.valid     = out_valid_r;
  assign out_if.left_out  = left_out_r;
  assign out_if.right_out = right_out_r;

  always_comb begin
    d_ext = DW'(delay_r);
    if (d_ext == '0) begin
      d_eff = DW'(1);
    end else if (d_ext > DW'(DELAY_DEPTH - 1)) begin
      d_eff = DW'(DELAY_DEPTH - 1);
    end else begin
      d_eff = d_ext;
    end
    wi_ext  = DW'(wi_r);
    rd_ext  = (wi_ext >= d_eff) ? (wi_ext - d_eff) : (wi_ext + DW'(DELAY_DEPTH) - d_eff);
    rd_addr = rd_ext[AW-1:0];
    fill_ok = wrapped_r || (rd_addr < wi_r);
    wi_wrap = (wi_r == AW'(DELAY_DEPTH - 1));
    wi_nxt  = wi_wrap ? '0 : wi_r + 1'b1;
  end

  always_comb begin
    ctl.mul_en   = (state_r == ST_MUL);
    ctl.sum_en   = (state_r == ST_SUM);
    ctl.fbm_en   = (state_r == ST_FBM);
    coef.damp_c  = damping_r;
    coef.damp_cm = UNITY - {1'b0, damping_r};
    coef.wet     = (wet_r > UNITY) ? UNITY : wet_r;
    coef.dry     = UNITY - coef.wet;
    coef.fb      = (feedback_r > FB_MAX) ? FB_MAX : feedback_r;
    del_l        = fill_ok_r ? rdata_l : '0;
    del_r        = fill_ok_r ? rdata_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r     <= DELAY_RST;
      feedback_r  <= '0;
      wet_r       <= WET_RST;
      damping_r   <= '0;
      ping_pong_r <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DELAY:     delay_r     <= cfg_wdata;
        REG_FEEDBACK:  feedback_r  <= cfg_wdata[15:0];
        REG_WET:       wet_r       <= cfg_wdata;
        REG_DAMPING:   damping_r   <= cfg_wdata[15:0];
        REG_PING_PONG: ping_pong_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      wi_r        <= '0;
      wrapped_r   <= 1'b0;
    end else begin
      if (mem_we) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            state_r   <= ST_MUL;
            left_r    <= in_if.left_in;
            right_r   <= in_if.right_in;
            fill_ok_r <= fill_ok;
          end
        end
        ST_MUL: state_r <= ST_SUM;
        ST_SUM: state_r <= ST_FBM;
        ST_FBM: state_r <= ST_WR;
        ST_WR: begin
          if (out_free) begin
            state_r     <= ST_IDLE;
            left_out_r  <= mix_l;
            right_out_r <= mix_r;
            wi_r        <= wi_nxt;
            if (wi_wrap) begin
              wrapped_r <= 1'b1;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  sfd_store #(
    .DEPTH (DELAY_DEPTH),
    .SB    (SB)
  ) u_store (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (wi_r),
    .wdata_l (wr_l),
    .wdata_r (wr_r),
    .raddr   (rd_addr),
    .rdata_l (rdata_l),
    .rdata_r (rdata_r)
  );

  sfd_lane #(
    .SAMPLE_BITS (SB)
  ) u_lane_l (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .coef    (coef),
    .dry_smp (left_r),
    .del_smp (del_l),
    .fb_term (fb_l),
    .mix_out (mix_l)
  );

  sfd_lane #(
    .SAMPLE_BITS (SB)
  ) u_lane_r (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .coef    (coef),
    .dry_smp (right_r),
    .del_smp (del_r),
    .fb_term (fb_r),
    .mix_out (mix_r)
  );

  sfd_merge #(
    .SAMPLE_BITS (SB)
  ) u_merge (
    .ping_pong (ping_pong_r),
    .left_smp  (left_r),
    .right_smp (right_r),
    .fb_left   (fb_l),
    .fb_right  (fb_r),
    .wr_left   (wr_l),
    .wr_right  (wr_r)
  );

`ifndef SYNTH
  a_write_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> out_valid_r)
    else $error("store write without result load");

  a_write_moves_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> (wi_r != $past(wi_r)))
    else $error("write pointer did not advance");

  a_wrap_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !$fell(wrapped_r))
    else $error("wrap flag cleared outside reset");
`endif

endmodule

@@ tb/sv/stereo_feedback_delay_tb.sv @@
// Self-checking testbench for the stereo feedback delay: directed and random sample pairs.
`timescale 1ns / 1ps

module stereo_feedback_delay_tb;
  import sfd_pkg::*;

  localparam int     DEPTH       = 131072;
  localparam int     SB          = 24;
  localparam int     DAMP_SH     = 32 - SB;
  localparam int     FB_SH       = COEF_BITS + DAMP_SH;
  localparam longint ONE_Q16     = longint'(UNITY);
  localparam longint FB_CAP      = longint'(FB_MAX);
  localparam longint SMP_HI      = (64'sd1 <<< (SB - 1)) - 1;
  localparam longint SMP_LO      = -(64'sd1 <<< (SB - 1));
  localparam int     LATENCY     = 5;
  localparam int     STUCK_LIMIT = 4000;
  localparam int     LONG_HOLD   = 400;

  localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};

  typedef struct {
    logic signed [SB-1:0] left;
    logic signed [SB-1:0] right;
  } mix_pair_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  sfd_in_if  #(.SAMPLE_BITS(SB)) in_ch ();
  sfd_out_if #(.SAMPLE_BITS(SB)) out_ch ();

  stereo_feedback_delay #(
    .DELAY_DEPTH(DEPTH),
    .SAMPLE_BITS(SB)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_ch),
    .out_if   (out_ch),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // delay line model state and register copies
  logic signed [SB-1:0] left_mem [int];
  logic signed [SB-1:0] right_mem [int];
  longint               wr_ptr;
  longint               lp_left;
  longint               lp_right;
  logic [16:0]          dly_len;
  logic [15:0]          fb_gain;
  logic [16:0]          wet_frac;
  logic [15:0]          damp_pole;
  logic                 cross_fb;

  mix_pair_t pending_mix[$];
  int        fail_count = 0;
  int        stuck_cycles = 0;
  int        hold_off_cycles = 0;
  bit        src_idle = 1'b0;
  bit        snk_idle = 1'b0;

  function automatic longint rnd_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v);
    if (v > SMP_HI) return SMP_HI;
    if (v < SMP_LO) return SMP_LO;
    return v;
  endfunction

  function automatic longint lowpass(longint st, longint dly, longint c);
    return rnd_shift(st * c + (dly <<< DAMP_SH) * (ONE_Q16 - c), COEF_BITS);
  endfunction

  function automatic void mix_and_feed(logic signed [SB-1:0] l_in, logic signed [SB-1:0] r_in);
    longint    l, r, d, fbk, wet, c, rd, dl, dr, fl, fr, wl, wr;
    mix_pair_t res;
    l   = longint'(l_in);
    r   = longint'(r_in);
    d   = longint'(dly_len);
    fbk = longint'(fb_gain);
    wet = longint'(wet_frac);
    c   = longint'(damp_pole);
    if (d < 1) d = 1;
    if (d > DEPTH - 1) d = DEPTH - 1;
    if (fbk > FB_CAP) fbk = FB_CAP;
    if (wet > ONE_Q16) wet = ONE_Q16;
    rd = (wr_ptr + DEPTH - d) % DEPTH;
    dl = left_mem.exists(int'(rd)) ? longint'(left_mem[int'(rd)]) : 0;
    dr = right_mem.exists(int'(rd)) ? longint'(right_mem[int'(rd)]) : 0;
    lp_left  = lowpass(lp_left, dl, c);
    lp_right = lowpass(lp_right, dr, c);
    fl = rnd_shift(fbk * lp_left, FB_SH);
    fr = rnd_shift(fbk * lp_right, FB_SH);
    if (cross_fb) begin
      wl = clip(((l + r) >>> 1) + fr);
      wr = clip(fl);
    end else begin
      wl = clip(l + fl);
      wr = clip(r + fr);
    end
    left_mem[int'(wr_ptr)]  = wl[SB-1:0];
    right_mem[int'(wr_ptr)] = wr[SB-1:0];
    res.left  = SB'(clip(rnd_shift(l * (ONE_Q16 - wet) + dl * wet, COEF_BITS)));
    res.right = SB'(clip(rnd_shift(r * (ONE_Q16 - wet) + dr * wet, COEF_BITS)));
    wr_ptr = (wr_ptr + 1) % DEPTH;
    pending_mix.push_back(res);
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_DELAY:     dly_len   = val[16:0];
      REG_FEEDBACK:  fb_gain   = val[15:0];
      REG_WET:       wet_frac  = val[16:0];
      REG_DAMPING:   damp_pole = val[15:0];
      REG_PING_PONG: cross_fb  = val[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_regs(logic [16:0] d, logic [16:0] fb, logic [16:0] wet,
                          logic [16:0] c, logic [16:0] pp);
    write_reg(REG_DELAY, d);
    write_reg(REG_FEEDBACK, fb);
    write_reg(REG_WET, wet);
    write_reg(REG_DAMPING, c);
    write_reg(REG_PING_PONG, pp);
  endtask

  task automatic send_pair(logic signed [SB-1:0] l, logic signed [SB-1:0] r);
    int gap;
    gap = src_idle ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.left_in  <= l;
    in_ch.right_in <= r;
    mix_and_feed(l, r);
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
  endtask

  task automatic wait_mix_drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_mix.size() != 0);
  endtask

  function automatic logic signed [SB-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return S_MAX;
      1: return S_MIN;
      2: return SB'($urandom_range(0, 15));
      3: return -SB'($urandom_range(1, 16));
      default: return SB'($urandom());
    endcase
  endfunction

  task automatic check_mix(logic signed [SB-1:0] l, logic signed [SB-1:0] r);
    mix_pair_t want;
    if (pending_mix.size() == 0) begin
      $error("result with nothing pending: left_out %0d, right_out %0d", l, r);
      fail_count++;
      return;
    end
    want = pending_mix.pop_front();
    if (l !== want.left) begin
      $error("left_out: expected %0d, got %0d", want.left, l);
      fail_count++;
    end
    if (r !== want.right) begin
      $error("right_out: expected %0d, got %0d", want.right, r);
      fail_count++;
    end
  endtask

  initial begin : mix_sink
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_off_cycles > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end
      stall = snk_idle ? $urandom_range(0, 16) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (out_ch.valid !== 1'b1) @(posedge clk);
      check_mix(out_ch.left_out, out_ch.right_out);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        stuck_cycles <= 0;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic test_reset_state();
    src_idle = 1'b1;
    snk_idle = 1'b1;
    send_pair(S_MAX, S_MIN);
    send_pair(S_MIN, S_MAX);
    wait_mix_drain();
  endtask

  task automatic test_saturation();
    src_idle = 1'b0;
    snk_idle = 1'b0;
    set_regs(17'd1, 17'(FB_MAX), 17'(UNITY), 17'd0, 17'd0);
    send_pair(S_MAX, S_MAX);
    send_pair(S_MAX, S_MAX);
    send_pair(S_MIN, S_MIN);
    send_pair(S_MIN, S_MIN);
    send_pair('0, '0);
    send_pair(S_MAX, S_MIN);
    wait_mix_drain();
  endtask

  task automatic test_ping_pong();
    src_idle = 1'b1;
    set_regs(17'd1, 17'(FB_MAX), 17'd40000, 17'd0, 17'd1);
    send_pair(S_MAX, S_MAX);
    send_pair(S_MIN, S_MAX);
    send_pair(-SB'(3), '0);
    send_pair(S_MIN, S_MIN);
    wait_mix_drain();
  endtask

  task automatic test_clamped_registers();
    snk_idle = 1'b1;
    set_regs(17'd0, 17'hFFFF, 17'h1FFFF, 17'd0, 17'd0);
    for (int i = int'(REG_PING_PONG) + 1; i < (1 << CFG_IDX_W); i++) begin
      write_reg(i[CFG_IDX_W-1:0], 17'($urandom()));
    end
    send_pair(S_MAX, -SB'(1));
    send_pair(SB'(1), S_MIN);
    send_pair(S_MIN, S_MAX);
    send_pair('0, '0);
    wait_mix_drain();
  endtask

  task automatic test_damping_and_long_delay();
    set_regs(17'd2, 17'd50000, 17'd65535, 17'd65535, 17'd0);
    send_pair(S_MAX, S_MIN);
    send_pair(S_MAX, S_MIN);
    send_pair(S_MIN, S_MAX);
    wait_mix_drain();
    write_reg(REG_DAMPING, 17'd32768);
    send_pair(S_MAX, S_MAX);
    send_pair(S_MIN, S_MIN);
    wait_mix_drain();
    set_regs(17'(DEPTH - 1), 17'(FB_MAX), 17'(UNITY), 17'd0, 17'd0);
    send_pair(S_MAX, S_MIN);
    send_pair(SB'(12345), -SB'(12345));
    wait_mix_drain();
  endtask

  task automatic randomize_regs();
    logic [16:0] v;
    case ($urandom_range(0, 6))
      0: v = 17'd0;
      1: v = 17'd1;
      2: v = 17'(DEPTH - 1);
      3: v = 17'($urandom_range(2, 600));
      4: v = 17'($urandom());
      default: v = 17'($urandom_range(1, 40));
    endcase
    write_reg(REG_DELAY, v);
    case ($urandom_range(0, 4))
      0: v = 17'd0;
      1: v = 17'(FB_MAX);
      2: v = 17'($urandom_range(int'(FB_MAX) + 1, 65535));
      3: v = 17'($urandom());
      default: v = 17'($urandom_range(30000, int'(FB_MAX)));
    endcase
    write_reg(REG_FEEDBACK, v);
    case ($urandom_range(0, 3))
      0: v = 17'd0;
      1: v = 17'(UNITY);
      2: v = 17'($urandom_range(int'(UNITY) + 1, 131071));
      default: v = 17'($urandom_range(0, int'(UNITY)));
    endcase
    write_reg(REG_WET, v);
    case ($urandom_range(0, 3))
      0: v = 17'd0;
      1: v = 17'd65535;
      default: v = 17'($urandom());
    endcase
    write_reg(REG_DAMPING, v);
    write_reg(REG_PING_PONG, 17'($urandom()));
  endtask

  task automatic test_backpressure();
    set_regs(17'd3, 17'd45000, 17'd50000, 17'd20000, 17'd0);
    src_idle = 1'b0;
    snk_idle = 1'b1;
    hold_off_cycles = LONG_HOLD;
    repeat (30) send_pair(pick_sample(), pick_sample());
    wait_mix_drain();
  endtask

  task automatic test_random_phases();
    repeat (11) begin
      randomize_regs();
      src_idle = 1'($urandom_range(0, 3) != 0);
      snk_idle = 1'($urandom_range(0, 3) != 0);
      repeat (52) send_pair(pick_sample(), pick_sample());
      wait_mix_drain();
    end
  endtask

  initial begin
    in_ch.valid    = 1'b0;
    in_ch.left_in  = '0;
    in_ch.right_in = '0;
    cfg_wr_en      = 1'b0;
    cfg_index      = REG_DELAY;
    cfg_wdata      = '0;
    rst_n          = 1'b0;
    wr_ptr         = 0;
    lp_left        = 0;
    lp_right       = 0;
    dly_len        = DELAY_RST;
    fb_gain        = '0;
    wet_frac       = WET_RST;
    damp_pole      = '0;
    cross_fb       = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_saturation();
    test_ping_pong();
    test_clamped_registers();
    test_damping_and_long_delay();
    test_backpressure();
    test_random_phases();
    repeat (4 * LATENCY) @(posedge clk);
    if (fail_count == 0 && pending_mix.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
